// ----- rtl/csvt_pkg.sv -----
package csvt_pkg;

  // Record length counter width
  localparam int LENGTH_BITS_DEF = 16;

  // Result queue depth (power of two, at least 2)
  localparam int FIFO_DEPTH = 4;

  // Special characters
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_FIELD_END  = 2'd1,
    KIND_RECORD_END = 2'd2
  } kind_t;

  // One result without its length
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       unc;
    logic       last;
  } res_t;

  // Results that one accepted item pushes into the queue
  typedef struct packed {
    logic [1:0] n;
    res_t       e0;
    res_t       e1;
  } push_t;

endpackage

// ----- rtl/csvt_if.sv -----
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface csvt_out_if #(
  parameter int LEN_W = csvt_pkg::LENGTH_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [7:0]          out_byte;
  csvt_pkg::kind_t     kind;
  logic [LEN_W-1:0]    record_length;
  logic                unclosed_quote;
  logic                last;

  modport source (output valid, output out_byte, output kind, output record_length,
                  output unclosed_quote, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input record_length,
                  input unclosed_quote, input last, output ready);
endinterface

// ----- rtl/csv_field_tokenizer.sv -----
// CSV field tokenizer.
// in_ch carries one raw byte of the stream per item, or a stream end marker
// (stream_end set, byte ignored). out_ch carries results: data bytes, field
// ends and record ends with the record length; last marks the final result
// of an input item. An item causes zero, one or two results.
// Each accepted item is parsed in the cycle it is accepted and its results
// are registered in a four-entry result queue; they show on out_ch once the
// results before them have been taken. One item is taken per clock as long
// as the queue has two free slots; sustained rate is one item per cycle when
// the receiver takes one result per cycle and no item yields two results;
// the two results of an item leave one at a time by the single result port.
// When the receiver stalls, results wait in the queue and in_ch.ready drops
// once fewer than two slots are free. Synchronous reset (rst_n low) clears
// the parse state (quote mode, held quote, held CR, open record, length
// count) and empties the queue. Stream end closes an open record and
// returns the parser to its reset state.
module csv_field_tokenizer #(
  parameter int LENGTH_BITS = csvt_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  csvt_in_if.sink    in_ch,
  csvt_out_if.source out_ch
);

  csvt_pkg::push_t        push;
  logic [LENGTH_BITS-1:0] push_len0;
  logic [LENGTH_BITS-1:0] push_len1;
  logic                   room;
  logic                   accept;

  assign in_ch.ready = room;
  assign accept = in_ch.valid && room;

  // Parser with its state
  csvt_core #(.LEN_W(LENGTH_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_ch.in_byte),
    .stream_end (in_ch.stream_end),
    .push       (push),
    .push_len0  (push_len0),
    .push_len1  (push_len1)
  );

  // Result queue
  csvt_fifo #(.LEN_W(LENGTH_BITS)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_len0 (push_len0),
    .push_len1 (push_len1),
    .room      (room),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/csvt_core.sv -----
module csvt_core #(
  parameter int LEN_W = csvt_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                stream_end,
  output csvt_pkg::push_t     push,
  output logic [LEN_W-1:0]    push_len0,
  output logic [LEN_W-1:0]    push_len1
);

  logic             quoted_r, quoted_nxt;
  logic             qheld_r, qheld_nxt;
  logic             crheld_r, crheld_nxt;
  logic             open_r, open_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;

  // Parse one item against the current state
  always_comb begin
    logic             q, qh, ch, ro, done;
    logic [LEN_W-1:0] cnt;
    logic             e_q, e_cr, e_main;
    csvt_pkg::res_t   main_r;
    logic [LEN_W-1:0] main_len;
    logic [1:0]       n;
    csvt_pkg::res_t   s0, s1;
    logic [LEN_W-1:0] l0, l1;

    q = quoted_r;
    qh = qheld_r;
    ch = crheld_r;
    ro = open_r;
    cnt = cnt_r;
    done = 1'b0;
    e_q = 1'b0;
    e_cr = 1'b0;
    e_main = 1'b0;
    main_r = '{data: 8'd0, kind: csvt_pkg::KIND_DATA, unc: 1'b0, last: 1'b0};
    main_len = '0;
    n = 2'd0;
    s0 = main_r;
    s1 = main_r;
    l0 = '0;
    l1 = '0;

    if (stream_end) begin
      // Close any open record, then clear everything
      if (open_r || crheld_r || qheld_r) begin
        n = 2'd1;
        s0.kind = csvt_pkg::KIND_RECORD_END;
        s0.unc = quoted_r && !qheld_r;
        l0 = cnt_r;
      end
      q = 1'b0;
      qh = 1'b0;
      ch = 1'b0;
      ro = 1'b0;
      cnt = '0;
    end else begin
      // Resolve a held quote: escaped quote or closing quote
      if (qh) begin
        qh = 1'b0;
        if (in_byte == csvt_pkg::CH_QUOTE) begin
          if (cnt != '1) cnt = cnt + 1'b1;
          ro = 1'b1;
          e_q = 1'b1;
          done = 1'b1;
        end else begin
          q = 1'b0;
        end
      end
      if (!done) begin
        // Release a held CR as data unless a LF follows
        if (ch) begin
          ch = 1'b0;
          if (in_byte != csvt_pkg::CH_LF) begin
            if (cnt != '1) cnt = cnt + 1'b1;
            e_cr = 1'b1;
          end
        end
        if (in_byte == csvt_pkg::CH_CR) begin
          ch = 1'b1;
          ro = 1'b1;
        end else if (in_byte == csvt_pkg::CH_QUOTE) begin
          if (cnt != '1) cnt = cnt + 1'b1;
          ro = 1'b1;
          if (q) qh = 1'b1;
          else q = 1'b1;
        end else if (in_byte == csvt_pkg::CH_COMMA && !q) begin
          if (cnt != '1) cnt = cnt + 1'b1;
          ro = 1'b1;
          e_main = 1'b1;
          main_r.kind = csvt_pkg::KIND_FIELD_END;
        end else if (in_byte == csvt_pkg::CH_LF && !q) begin
          e_main = 1'b1;
          main_r.kind = csvt_pkg::KIND_RECORD_END;
          main_len = cnt;
          cnt = '0;
          ro = 1'b0;
        end else begin
          if (cnt != '1) cnt = cnt + 1'b1;
          ro = 1'b1;
          e_main = 1'b1;
          main_r.data = in_byte;
        end
      end

      // Order the results into queue slots
      if (e_q) begin
        n = 2'd1;
        s0.data = csvt_pkg::CH_QUOTE;
      end else if (e_cr) begin
        s0.data = csvt_pkg::CH_CR;
        s1 = main_r;
        l1 = main_len;
        n = e_main ? 2'd2 : 2'd1;
      end else if (e_main) begin
        n = 2'd1;
        s0 = main_r;
        l0 = main_len;
      end
    end

    s0.last = (n == 2'd1);
    s1.last = 1'b1;

    quoted_nxt = q;
    qheld_nxt = qh;
    crheld_nxt = ch;
    open_nxt = ro;
    cnt_nxt = cnt;

    push.n = accept ? n : 2'd0;
    push.e0 = s0;
    push.e1 = s1;
    push_len0 = l0;
    push_len1 = l1;
  end

  // Advance parse state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quoted_r <= 1'b0;
      qheld_r <= 1'b0;
      crheld_r <= 1'b0;
      open_r <= 1'b0;
      cnt_r <= '0;
    end else if (accept) begin
      quoted_r <= quoted_nxt;
      qheld_r <= qheld_nxt;
      crheld_r <= crheld_nxt;
      open_r <= open_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/csvt_fifo.sv -----
module csvt_fifo #(
  parameter int LEN_W = csvt_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csvt_pkg::push_t    push,
  input  logic [LEN_W-1:0]   push_len0,
  input  logic [LEN_W-1:0]   push_len1,
  output logic               room,
  csvt_out_if.source         out_ch
);

  localparam int DEPTH = csvt_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  csvt_pkg::res_t   mem_r [DEPTH];
  logic [LEN_W-1:0] len_mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_p1;

  // Take an item only with room for its two possible results
  assign room = (count_r <= (PTR_W+1)'(DEPTH - 2));

  assign pop = out_ch.valid && out_ch.ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  // Show the head of the queue
  assign out_ch.valid = (count_r != '0);
  assign out_ch.out_byte = mem_r[rd_ptr_r].data;
  assign out_ch.kind = mem_r[rd_ptr_r].kind;
  assign out_ch.unclosed_quote = mem_r[rd_ptr_r].unc;
  assign out_ch.last = mem_r[rd_ptr_r].last;
  assign out_ch.record_length = len_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt = count_r + (PTR_W+1)'(push.n) - (PTR_W+1)'(pop);
  end

  // Write pushed results
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.e0;
      len_mem_r[wr_ptr_r] <= push_len0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.e1;
      len_mem_r[wr_ptr_p1] <= push_len1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/csvt_checker.sv -----
module csvt_checker #(
  parameter int LEN_W = csvt_pkg::LENGTH_BITS_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [7:0]       out_byte,
  input csvt_pkg::kind_t  out_kind,
  input logic [LEN_W-1:0] out_len,
  input logic             out_unc,
  input logic             out_last
);

  // Nothing shows right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_kind) && $stable(out_len))
    else $error("result changed while stalled");

  // Length only travels with a record end
  a_len_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != csvt_pkg::KIND_RECORD_END |-> out_len == '0)
    else $error("length on a non record end");

  // Unclosed quote flag only on a final record end
  a_unc_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unc |-> out_kind == csvt_pkg::KIND_RECORD_END && out_last)
    else $error("unclosed quote flag out of place");

endmodule

bind csv_field_tokenizer csvt_checker #(.LEN_W(LENGTH_BITS)) u_csvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_kind  (out_ch.kind),
  .out_len   (out_ch.record_length),
  .out_unc   (out_ch.unclosed_quote),
  .out_last  (out_ch.last)
);
